@@ rtl/rrcs_pkg.sv @@
// shared constants, command codes and controller/datapath interface types
`default_nettype none
package rrcs_pkg;
  localparam int MAX_RECTS     = 64;
  localparam int MAX_INTERVALS = 64;
  localparam int IDX_W = $clog2(MAX_RECTS);
  localparam int CNT_W = $clog2(MAX_RECTS + 1);
  localparam int N_W   = $clog2(MAX_INTERVALS + 1);
  localparam int COORD_W = 16;
  localparam int EDGE_W  = 17;
  localparam int ENTRY_W = 4 * COORD_W;

  typedef enum logic [2:0] {
    FUNC_ADD   = 3'd0,
    FUNC_CLEAR = 3'd1,
    FUNC_POINT = 3'd2,
    FUNC_HITS  = 3'd3,
    FUNC_COVER = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DISPATCH, ST_BAND, ST_ISSUE, ST_LOAD, ST_EVAL, ST_PASS_END
  } state_t;

  typedef struct packed {
    logic load_cmd;
    logic wr_en;
    logic clr_cnt;
    logic y_init;
    logic y_adv;
    logic band_init;
    logic pass_init;
    logic idx_clr;
    logic idx_inc;
    logic ld_en;
    logic eval_en;
    logic respond;
    logic ans;
    logic drop;
  } ctl_t;

  typedef struct packed {
    logic [2:0] func;
    logic       q_empty;
    logic       full;
    logic       count_zero;
    logic       idx_last;
    logic       hit;
    logic       first;
    logic       n_zero;
    logic       n_full;
    logic       reach_ok;
    logic       changed;
    logic       y_done;
  } sts_t;
endpackage
`default_nettype wire

@@ rtl/rrcs_ram.sv @@
// generic single-write ram with registered read
`default_nettype none
module rrcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/rrcs_ctrl.sv @@
// command sequencer for add, clear and the three scans over the store
`default_nettype none
module rrcs_ctrl import rrcs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire sts_t sts,
  output ctl_t      ctl
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.load_cmd = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        priority case (sts.func)
          FUNC_ADD: begin
            ctl.wr_en = !sts.q_empty && !sts.full;
            ctl.drop = !sts.q_empty && sts.full;
            ctl.respond = 1'b1;
            state_nxt = ST_IDLE;
          end
          FUNC_CLEAR: begin
            ctl.clr_cnt = 1'b1;
            ctl.respond = 1'b1;
            state_nxt = ST_IDLE;
          end
          FUNC_POINT, FUNC_HITS: begin
            if (sts.count_zero || (sts.func == FUNC_HITS && sts.q_empty)) begin
              ctl.respond = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              ctl.idx_clr = 1'b1;
              state_nxt = ST_ISSUE;
            end
          end
          FUNC_COVER: begin
            if (sts.q_empty) begin
              ctl.ans = 1'b1;
              ctl.respond = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              ctl.y_init = 1'b1;
              state_nxt = ST_BAND;
            end
          end
          default: begin
            ctl.respond = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_BAND: begin
        if (sts.y_done) begin
          ctl.ans = 1'b1;
          ctl.respond = 1'b1;
          state_nxt = ST_IDLE;
        end else if (sts.count_zero) begin
          ctl.respond = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          ctl.band_init = 1'b1;
          ctl.idx_clr = 1'b1;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: state_nxt = ST_LOAD;
      ST_LOAD: begin
        ctl.ld_en = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        ctl.eval_en = 1'b1;
        if (sts.idx_last) begin
          state_nxt = ST_PASS_END;
        end else begin
          ctl.idx_inc = 1'b1;
          state_nxt = ST_ISSUE;
        end
      end
      ST_PASS_END: begin
        if (sts.func != FUNC_COVER) begin
          ctl.ans = sts.hit;
          ctl.respond = 1'b1;
          state_nxt = ST_IDLE;
        end else if (sts.first && sts.n_zero) begin
          ctl.respond = 1'b1;
          state_nxt = ST_IDLE;
        end else if ((sts.first && sts.n_full) || sts.reach_ok) begin
          // fragmented rows count as covered
          ctl.y_adv = 1'b1;
          state_nxt = ST_BAND;
        end else if (!sts.changed) begin
          ctl.respond = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          ctl.pass_init = 1'b1;
          ctl.idx_clr = 1'b1;
          state_nxt = ST_ISSUE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/rrcs_dp.sv @@
// datapath: command registers, rectangle store, scan compare and result registers
`default_nettype none
module rrcs_dp import rrcs_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [2:0]                in_func,
  input  wire logic signed [COORD_W-1:0] in_rect_x,
  input  wire logic signed [COORD_W-1:0] in_rect_y,
  input  wire logic signed [COORD_W-1:0] in_rect_w,
  input  wire logic signed [COORD_W-1:0] in_rect_h,
  input  wire ctl_t                      ctl,
  output sts_t                           sts,
  output logic                           out_valid,
  output logic                           out_answer,
  output logic [6:0]                     out_stored_count,
  output logic                           out_dropped
);
  logic [2:0]                func_r;
  logic signed [COORD_W-1:0] qx_r, qy_r, qw_r, qh_r;
  logic signed [EDGE_W-1:0]  qx, qy, qright, qbot;
  logic [CNT_W-1:0]          count_r;
  logic [IDX_W-1:0]          idx_r;
  logic [ENTRY_W-1:0]        rdata;
  logic signed [EDGE_W-1:0]  el_r, et_r, er_r, eb_r;
  logic signed [EDGE_W-1:0]  y_r, next_r, reach_r;
  logic signed [EDGE_W-1:0]  a0, a1, nx1, nx2;
  logic [N_W-1:0]            n_r;
  logic                      hit_r, first_r, changed_r;
  logic                      pt_hit, rc_hit, live, active, extend;
  logic                      valid_r, ans_r, drop_r;
  logic [CNT_W-1:0]          count_nxt;
  logic [6:0]                cnt_out_r;

  assign qx = EDGE_W'(qx_r);
  assign qy = EDGE_W'(qy_r);
  assign qright = qx + EDGE_W'(qw_r);
  assign qbot = qy + EDGE_W'(qh_r);

  rrcs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_RECTS)) u_store (
    .clk(clk),
    .we(ctl.wr_en),
    .waddr(count_r[IDX_W-1:0]),
    .wdata({qx_r, qy_r, qw_r, qh_r}),
    .raddr(idx_r),
    .rdata_r(rdata)
  );

  // per-entry compare on the registered store fields
  assign pt_hit = (qx >= el_r) && (qx < er_r) && (qy >= et_r) && (qy < eb_r);
  assign rc_hit = (el_r < qright) && (qx < er_r) && (et_r < qbot) && (qy < eb_r);
  assign a0 = (qx > el_r) ? qx : el_r;
  assign a1 = (qright < er_r) ? qright : er_r;
  assign live = (a1 > a0);
  assign active = live && (et_r <= y_r) && (y_r < eb_r);
  assign extend = active && (a0 <= reach_r) && (a1 > reach_r);
  assign nx1 = (et_r > y_r && et_r < next_r) ? et_r : next_r;
  assign nx2 = (eb_r > y_r && eb_r < nx1) ? eb_r : nx1;

  always_comb begin
    count_nxt = count_r;
    if (ctl.clr_cnt) begin
      count_nxt = '0;
    end else if (ctl.wr_en) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= ctl.respond;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_cmd) begin
      func_r <= in_func;
      qx_r <= in_rect_x;
      qy_r <= in_rect_y;
      qw_r <= in_rect_w;
      qh_r <= in_rect_h;
      hit_r <= 1'b0;
    end
    if (ctl.respond) begin
      ans_r <= ctl.ans;
      drop_r <= ctl.drop;
      cnt_out_r <= 7'(count_nxt);
    end
    if (ctl.idx_clr) begin
      idx_r <= '0;
    end else if (ctl.idx_inc) begin
      idx_r <= idx_r + IDX_W'(1);
    end
    if (ctl.ld_en) begin
      el_r <= EDGE_W'($signed(rdata[4*COORD_W-1:3*COORD_W]));
      et_r <= EDGE_W'($signed(rdata[3*COORD_W-1:2*COORD_W]));
      er_r <= EDGE_W'($signed(rdata[4*COORD_W-1:3*COORD_W]))
            + EDGE_W'($signed(rdata[2*COORD_W-1:COORD_W]));
      eb_r <= EDGE_W'($signed(rdata[3*COORD_W-1:2*COORD_W]))
            + EDGE_W'($signed(rdata[COORD_W-1:0]));
    end
    if (ctl.y_init) begin
      y_r <= qy;
    end else if (ctl.y_adv) begin
      y_r <= next_r;
    end
    if (ctl.band_init) begin
      next_r <= qbot;
      n_r <= '0;
      reach_r <= qx;
      first_r <= 1'b1;
      changed_r <= 1'b0;
    end else if (ctl.pass_init) begin
      first_r <= 1'b0;
      changed_r <= 1'b0;
    end else if (ctl.eval_en) begin
      if (func_r == FUNC_POINT && pt_hit) begin
        hit_r <= 1'b1;
      end
      if (func_r == FUNC_HITS && rc_hit) begin
        hit_r <= 1'b1;
      end
      if (func_r == FUNC_COVER && live) begin
        next_r <= nx2;
        if (first_r && active && n_r < N_W'(MAX_INTERVALS)) begin
          n_r <= n_r + N_W'(1);
        end
        if (extend) begin
          reach_r <= a1;
          changed_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    sts.func = func_r;
    sts.q_empty = (qw_r <= 0) || (qh_r <= 0);
    sts.full = (count_r >= CNT_W'(MAX_RECTS));
    sts.count_zero = (count_r == '0);
    sts.idx_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
    sts.hit = hit_r;
    sts.first = first_r;
    sts.n_zero = (n_r == '0);
    sts.n_full = (n_r >= N_W'(MAX_INTERVALS));
    sts.reach_ok = (reach_r >= qright);
    sts.changed = changed_r;
    sts.y_done = (y_r >= qbot);
  end

  assign out_valid = valid_r;
  assign out_answer = ans_r;
  assign out_dropped = drop_r;
  assign out_stored_count = cnt_out_r;
endmodule
`default_nettype wire

@@ rtl/rect_region_coverage_store.sv @@
// top level of the rectangle store with point, overlap and coverage queries
`default_nettype none
// A command beat is taken when start is high and busy is low; its single
// result is shown for one cycle on the out_ ports with out_valid and cannot be held
// off. Point and overlap queries walk the store one stored rectangle at a
// time in three steps (memory read, edge sum, compare). Coverage walks the
// store once per band of rows and repeats the walk while the reached column
// keeps growing; each walk reads the rectangles one at a time through the
// single read port.
module rect_region_coverage_store import rrcs_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [2:0]                in_func,
  input  wire logic signed [COORD_W-1:0] in_rect_x,
  input  wire logic signed [COORD_W-1:0] in_rect_y,
  input  wire logic signed [COORD_W-1:0] in_rect_w,
  input  wire logic signed [COORD_W-1:0] in_rect_h,
  output logic                           out_valid,
  output logic                           out_answer,
  output logic [6:0]                     out_stored_count,
  output logic                           out_dropped
);
  ctl_t ctl;
  sts_t sts;

  rrcs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .ctl(ctl)
  );

  rrcs_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_func(in_func), .in_rect_x(in_rect_x), .in_rect_y(in_rect_y),
    .in_rect_w(in_rect_w), .in_rect_h(in_rect_h),
    .ctl(ctl), .sts(sts),
    .out_valid(out_valid), .out_answer(out_answer),
    .out_stored_count(out_stored_count), .out_dropped(out_dropped)
  );
endmodule
`default_nettype wire

@@ rtl/rrcs_checker.sv @@
// port-level checks on the rectangle store, bound to the top level
`default_nettype none
module rrcs_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic       out_answer,
  input wire logic [6:0] out_stored_count,
  input wire logic       out_dropped
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("no busy after accepted beat");
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_valid_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result longer than one cycle");
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> out_stored_count == 7'd64 && !out_answer)
    else $error("drop without full store");
endmodule

bind rect_region_coverage_store rrcs_checker u_rrcs_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_answer(out_answer),
  .out_stored_count(out_stored_count), .out_dropped(out_dropped)
);
`default_nettype wire
